FILE: sv/stk_pkg.sv
// ----------------------------------------------------------------------------
// Sorted top-k table package
// Shared constants, codes, state type and control structs.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int LIMIT_W      = 11;
    localparam int INDEX_W      = 10;
    localparam int SCORE_W      = 32;
    localparam int PORT_KEY_W   = 32;
    localparam int STATUS_W     = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd999;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_IMPROVED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_IMPR = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FELL_OFF = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_READ_OK  = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_READ_OOR = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_READ_RD,
        ST_FINISH
    } stk_state_t;

    typedef struct packed {
        logic load;
        logic scan_issue;
        logic scan_step;
        logic decide;
        logic shift_issue;
        logic shift_write;
        logic place_write;
        logic read_issue;
        logic finish;
    } stk_cmd_t;

    typedef struct packed {
        logic in_read;
        logic in_key_zero;
        logic count_zero;
        logic scan_last;
        logic scan_hit;
        logic shift_more;
        logic do_place;
    } stk_sts_t;

endpackage

FILE: sv/sorted_topk_unique_key_table.sv
// ----------------------------------------------------------------------------
// Sorted top-k unique key table
// Keeps (key, score) entries in descending score order, one entry per key.
// ----------------------------------------------------------------------------
// An insert scans the stored entries for the key and then shifts entries one
// place down to make room at the insertion point; both loops run through
// the single read port of the table memories. A read issues one memory read.
// The result strobe follows the last cycle; the receiver cannot stall it.
// Reset clears the count and sets the limit to 999; the memories need no clear.
module sorted_topk_unique_key_table #(
    parameter int CAPACITY = stk_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = stk_pkg::KEY_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [stk_pkg::PORT_KEY_W-1:0]     player_key,
    input  logic signed [stk_pkg::SCORE_W-1:0] new_score,
    input  logic [stk_pkg::INDEX_W-1:0]        read_index,
    output logic                               result_valid,
    output logic [stk_pkg::STATUS_W-1:0]       status,
    output logic [stk_pkg::INDEX_W-1:0]        rank,
    output logic [stk_pkg::LIMIT_W-1:0]        entry_total,
    output logic [stk_pkg::PORT_KEY_W-1:0]     key_out,
    output logic signed [stk_pkg::SCORE_W-1:0] score_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stk_pkg::LIMIT_W-1:0]        cfg_data
);
    import stk_pkg::*;

    stk_cmd_t cmd;
    stk_sts_t sts;

    assign cfg_ready = 1'b1;

    stk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    stk_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .player_key   (player_key),
        .new_score    (new_score),
        .read_index   (read_index),
        .result_valid (result_valid),
        .status       (status),
        .rank         (rank),
        .entry_total  (entry_total),
        .key_out      (key_out),
        .score_out    (score_out)
    );

endmodule

FILE: sv/stk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/stk_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted top-k table controller
// Sequences the key search, the entry shift, the placement and reads.
// ----------------------------------------------------------------------------
module stk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  stk_pkg::stk_sts_t sts,
    output stk_pkg::stk_cmd_t cmd,
    output logic              busy
);
    import stk_pkg::*;

    stk_state_t state_reg;
    stk_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (sts.in_read)
                        state_next = ST_READ_RD;
                    else if (sts.in_key_zero)
                        state_next = ST_FINISH;
                    else if (sts.count_zero)
                        state_next = ST_DECIDE;
                    else
                        state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (sts.scan_hit || sts.scan_last)
                    state_next = ST_DECIDE;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_DECIDE:   state_next = ST_SHIFT_RD;
            ST_SHIFT_RD:
            begin
                if (!sts.do_place)
                    state_next = ST_FINISH;
                else if (sts.shift_more)
                    state_next = ST_SHIFT_WR;
                else
                    state_next = ST_PLACE;
            end
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_PLACE:    state_next = ST_FINISH;
            ST_READ_RD:  state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN_RD:  cmd.scan_issue  = 1'b1;
            ST_SCAN_CHK: cmd.scan_step   = 1'b1;
            ST_DECIDE:   cmd.decide      = 1'b1;
            ST_SHIFT_RD: cmd.shift_issue = sts.do_place && sts.shift_more;
            ST_SHIFT_WR: cmd.shift_write = 1'b1;
            ST_PLACE:    cmd.place_write = 1'b1;
            ST_READ_RD:  cmd.read_issue  = 1'b1;
            ST_FINISH:   cmd.finish      = 1'b1;
            default:     busy            = 1'b1;
        endcase
    end

endmodule

FILE: sv/stk_datapath.sv
// ----------------------------------------------------------------------------
// Sorted top-k table datapath
// Holds the key and score memories, the count, the limit and the result.
// ----------------------------------------------------------------------------
module stk_datapath #(
    parameter int CAPACITY = stk_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = stk_pkg::KEY_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stk_pkg::stk_cmd_t                  cmd,
    output stk_pkg::stk_sts_t                  sts,
    input  logic                               cfg_we,
    input  logic [stk_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                               opcode,
    input  logic [stk_pkg::PORT_KEY_W-1:0]     player_key,
    input  logic signed [stk_pkg::SCORE_W-1:0] new_score,
    input  logic [stk_pkg::INDEX_W-1:0]        read_index,
    output logic                               result_valid,
    output logic [stk_pkg::STATUS_W-1:0]       status,
    output logic [stk_pkg::INDEX_W-1:0]        rank,
    output logic [stk_pkg::LIMIT_W-1:0]        entry_total,
    output logic [stk_pkg::PORT_KEY_W-1:0]     key_out,
    output logic signed [stk_pkg::SCORE_W-1:0] score_out
);
    import stk_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [LIMIT_W-1:0]        entry_limit_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      result_valid_reg;
    logic                      op_reg;
    logic [KEY_BITS-1:0]       key_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [INDEX_W-1:0]        ridx_reg;
    logic [CNT_W-1:0]          i_reg;
    logic [CNT_W-1:0]          j_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic                      pos_set_reg;
    logic                      found_reg;
    logic [CNT_W-1:0]          found_idx_reg;
    logic signed [SCORE_W-1:0] found_score_reg;
    logic                      placed_reg;
    logic [STATUS_W-1:0]       ins_status_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [INDEX_W-1:0]        rank_reg;
    logic [LIMIT_W-1:0]        total_reg;
    logic [PORT_KEY_W-1:0]     key_out_reg;
    logic signed [SCORE_W-1:0] score_out_reg;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [IDX_W-1:0]          ram_raddr;
    logic [KEY_BITS-1:0]       ram_wkey;
    logic [SCORE_W-1:0]        ram_wscore;
    logic [KEY_BITS-1:0]       rd_key;
    logic [SCORE_W-1:0]        rd_score_raw;
    logic signed [SCORE_W-1:0] rd_score;
    logic [CNT_W-1:0]          eff_limit;
    logic [CNT_W-1:0]          count_fin;
    logic                      read_ok;
    logic                      fell_off;

    assign rd_score = signed'(rd_score_raw);
    assign read_ok  = 32'(ridx_reg) < 32'(count_reg);

    always_comb
    begin
        if (entry_limit_reg == '0)
            eff_limit = CNT_W'(1);
        else if (32'(entry_limit_reg) > 32'(CAPACITY))
            eff_limit = CNT_W'(CAPACITY);
        else
            eff_limit = CNT_W'(entry_limit_reg);
        count_fin = (count_reg > eff_limit) ? eff_limit : count_reg;
        fell_off  = placed_reg && (pos_reg >= count_fin);
    end

    always_comb
    begin
        sts.in_read     = (opcode == OP_READ);
        sts.in_key_zero = (KEY_BITS'(player_key) == '0);
        sts.count_zero  = (count_reg == '0);
        sts.scan_last   = ((CNT_W + 1)'(i_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count_reg);
        sts.scan_hit    = (rd_key == key_reg);
        sts.shift_more  = (j_reg > pos_reg);
        sts.do_place    = placed_reg && (32'(pos_reg) < 32'(CAPACITY));
    end

    always_comb
    begin
        ram_we     = cmd.shift_write || cmd.place_write;
        ram_waddr  = cmd.shift_write ? IDX_W'(j_reg) : IDX_W'(pos_reg);
        ram_wkey   = cmd.shift_write ? rd_key : key_reg;
        ram_wscore = cmd.shift_write ? rd_score_raw : score_reg;
        if (cmd.shift_issue)
            ram_raddr = IDX_W'(j_reg - CNT_W'(1));
        else if (cmd.read_issue)
            ram_raddr = IDX_W'(ridx_reg);
        else if (cmd.scan_issue)
            ram_raddr = IDX_W'(i_reg);
        else
            ram_raddr = '0;
    end

    stk_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wkey),
        .raddr (ram_raddr),
        .rdata (rd_key)
    );

    stk_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (CAPACITY)
    ) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wscore),
        .raddr (ram_raddr),
        .rdata (rd_score_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_limit_reg  <= LIMIT_RESET;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.finish;
            if (cfg_we)
                entry_limit_reg <= cfg_data;
            if (cmd.decide && !found_reg && (32'(pos_reg) < 32'(CAPACITY))
                && (32'(count_reg) < 32'(CAPACITY)))
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.finish && (op_reg == OP_INSERT) && (key_reg != '0))
                count_reg <= count_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode;
            key_reg     <= KEY_BITS'(player_key);
            score_reg   <= new_score;
            ridx_reg    <= read_index;
            i_reg       <= '0;
            pos_reg     <= count_reg;
            pos_set_reg <= 1'b0;
            found_reg   <= 1'b0;
            placed_reg  <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (!pos_set_reg && (rd_score < score_reg))
            begin
                pos_reg     <= i_reg;
                pos_set_reg <= 1'b1;
            end
            if (rd_key == key_reg)
            begin
                found_reg       <= 1'b1;
                found_idx_reg   <= i_reg;
                found_score_reg <= rd_score;
            end
            i_reg <= i_reg + CNT_W'(1);
        end
        if (cmd.decide)
        begin
            if (found_reg)
            begin
                if (found_score_reg < score_reg)
                begin
                    ins_status_reg <= STAT_IMPROVED;
                    placed_reg     <= 1'b1;
                    j_reg          <= found_idx_reg;
                end
                else
                begin
                    ins_status_reg <= STAT_NOT_IMPR;
                    j_reg          <= pos_reg;
                end
            end
            else
            begin
                ins_status_reg <= STAT_NEW;
                placed_reg     <= 1'b1;
                if (32'(count_reg) < 32'(CAPACITY))
                    j_reg <= count_reg;
                else
                    j_reg <= count_reg - CNT_W'(1);
            end
        end
        if (cmd.shift_write)
            j_reg <= j_reg - CNT_W'(1);
        if (cmd.finish)
        begin
            key_out_reg   <= '0;
            score_out_reg <= '0;
            rank_reg      <= '0;
            if (op_reg == OP_READ)
            begin
                total_reg <= LIMIT_W'(count_reg);
                if (read_ok)
                begin
                    status_reg    <= STAT_READ_OK;
                    key_out_reg   <= PORT_KEY_W'(rd_key);
                    score_out_reg <= rd_score;
                end
                else
                begin
                    status_reg <= STAT_READ_OOR;
                end
            end
            else if (key_reg == '0)
            begin
                status_reg <= STAT_IGNORED;
                total_reg  <= LIMIT_W'(count_reg);
            end
            else
            begin
                total_reg <= LIMIT_W'(count_fin);
                if (fell_off)
                    status_reg <= STAT_FELL_OFF;
                else
                begin
                    status_reg <= ins_status_reg;
                    if (placed_reg)
                        rank_reg <= INDEX_W'(pos_reg);
                end
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign rank         = rank_reg;
    assign entry_total  = total_reg;
    assign key_out      = key_out_reg;
    assign score_out    = score_out_reg;

endmodule
